FILE: rtl/sobx_pkg.sv
package sobx_pkg;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // fixed field widths
    localparam int CNT_W   = 13;
    localparam int LIMIT_W = 7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] new_incarnation;
        logic [63:0] new_origin_claim;
        logic [63:0] new_scan_epoch;
        logic [7:0]  new_kind;
        logic [63:0] new_chunk_id;
        logic [15:0] new_part_type;
        logic [63:0] new_observed_ms;
        logic [63:0] ack_up_to;
        logic [6:0]  read_limit;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] item_sequence;
        logic [63:0] item_incarnation;
        logic [63:0] item_origin_claim;
        logic [63:0] item_scan_epoch;
        logic [7:0]  item_kind;
        logic [63:0] item_chunk_id;
        logic [15:0] item_part_type;
        logic [63:0] item_observed_ms;
        logic [12:0] dropped_count;
        logic [12:0] pending_count;
        logic        last;
    } rsp_t;

    // one stored evidence record
    typedef struct packed {
        logic [63:0] incarnation;
        logic [63:0] origin_claim;
        logic [63:0] scan_epoch;
        logic [7:0]  kind;
        logic [63:0] chunk_id;
        logic [15:0] part_type;
        logic [63:0] observed_ms;
    } rec_t;

    // port signals of the record store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

endpackage

FILE: rtl/sobx_store.sv
module sobx_store
    import sobx_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] wr_addr,
    input  rec_t          wr_data,
    input  logic [AW-1:0] rd_addr,
    output rec_t          rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sequenced_outbox_cumulative_ack_unit.sv
// Sequenced outbox: a FIFO of up to DEPTH evidence records held in one
// synchronous record memory, each record numbered by a 64-bit sequence counter
// that starts at one and wraps. Append, acknowledge and unknown operations each
// give one transfer; a cumulative acknowledge drops front records up to the
// given sequence, and a read gives min(read_limit, pending records, MAX_BURST)
// transfers, or one transfer with ok low when that is zero. For a read, the
// cycle the request is taken issues the first memory read, and the single read
// port then supplies one record a cycle while the result side keeps up. New
// requests are taken only while no read burst is running and the output
// register is free or being emptied. The record memory needs no clearing after
// reset; only entries that hold pending records are ever read.
module sequenced_outbox_cumulative_ack_unit
    import sobx_pkg::*;
#(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic req_valid,
    output logic req_stall,
    input  req_t req,

    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;

    localparam logic [AW-1:0]      LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [SW-1:0]      DEPTH_SW  = SW'(DEPTH);
    localparam logic [CW-1:0]      DEPTH_CW  = CW'(DEPTH);
    localparam logic [LIMIT_W-1:0] BURST_MAX = LIMIT_W'(MAX_BURST);

    // controller states
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    // control state
    logic                state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [63:0]         head_seq_reg, head_seq_next;
    logic [63:0]         next_seq_reg, next_seq_next;

    // burst tracking
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [63:0]         rd_seq_reg, rd_seq_next;
    logic [LIMIT_W-1:0]  left_reg, left_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;

    // memory side
    store_ctl_t          st_ctl;
    logic [AW-1:0]       rd_addr;
    rec_t                wr_rec;
    rec_t                rd_rec;

    logic                out_free;
    logic                accept;

    // acknowledge arithmetic
    logic [64:0]         ack_diff;
    logic [63:0]         ack_dist;
    logic [CW-1:0]       drop;
    logic [SW-1:0]       head_sum;

    // read length
    logic [LIMIT_W-1:0]  lim;
    logic [LIMIT_W-1:0]  burst_n;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    assign wr_rec.incarnation  = req.new_incarnation;
    assign wr_rec.origin_claim = req.new_origin_claim;
    assign wr_rec.scan_epoch   = req.new_scan_epoch;
    assign wr_rec.kind         = req.new_kind;
    assign wr_rec.chunk_id     = req.new_chunk_id;
    assign wr_rec.part_type    = req.new_part_type;
    assign wr_rec.observed_ms  = req.new_observed_ms;

    // records below the head sequence are already gone; an ack below it drops none
    always_comb
    begin
        ack_diff = {1'b0, req.ack_up_to} - {1'b0, head_seq_reg};
        ack_dist = ack_diff[63:0];
        if (ack_diff[64])
        begin
            drop = '0;
        end
        else if (ack_dist >= 64'(cnt_reg))
        begin
            drop = cnt_reg;
        end
        else
        begin
            drop = CW'(ack_dist) + CW'(1);
        end
        head_sum = SW'(head_reg) + SW'(drop);
    end

    always_comb
    begin
        lim     = (req.read_limit > BURST_MAX) ? BURST_MAX : req.read_limit;
        burst_n = (MW'(cnt_reg) < MW'(lim)) ? LIMIT_W'(cnt_reg) : lim;
    end

    // first read of a burst goes to the head, later ones to the next slot
    assign rd_addr = (state_reg == ST_IDLE) ? head_reg : ptr_inc(rd_ptr_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        head_seq_next  = head_seq_reg;
        next_seq_next  = next_seq_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_seq_next    = rd_seq_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        st_ctl.wr_en   = 1'b0;
        st_ctl.rd_en   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default: a single transfer with empty record fields
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.last         = 1'b1;
                    out_next.pending_count = CNT_W'(cnt_reg);
                    case (req.operation)
                        OP_APPEND:
                        begin
                            if (cnt_reg != DEPTH_CW)
                            begin
                                st_ctl.wr_en           = 1'b1;
                                tail_next              = ptr_inc(tail_reg);
                                cnt_next               = cnt_reg + CW'(1);
                                next_seq_next          = next_seq_reg + 64'd1;
                                out_next.ok            = 1'b1;
                                out_next.item_sequence = next_seq_reg;
                                out_next.pending_count = CNT_W'(cnt_reg + CW'(1));
                            end
                        end
                        OP_ACK:
                        begin
                            head_next              = (head_sum >= DEPTH_SW) ?
                                                     AW'(head_sum - DEPTH_SW) :
                                                     AW'(head_sum);
                            cnt_next               = cnt_reg - drop;
                            head_seq_next          = head_seq_reg + 64'(drop);
                            out_next.ok            = 1'b1;
                            out_next.dropped_count = CNT_W'(drop);
                            out_next.pending_count = CNT_W'(cnt_reg - drop);
                        end
                        OP_READ:
                        begin
                            if (burst_n != '0)
                            begin
                                // no transfer yet, the burst supplies them
                                out_valid_next = 1'b0;
                                st_ctl.rd_en   = 1'b1;
                                rd_ptr_next    = head_reg;
                                rd_seq_next    = head_seq_reg;
                                left_next      = burst_n;
                                state_next     = ST_BURST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next                  = '0;
                    out_next.ok               = 1'b1;
                    out_next.item_sequence    = rd_seq_reg;
                    out_next.item_incarnation = rd_rec.incarnation;
                    out_next.item_origin_claim = rd_rec.origin_claim;
                    out_next.item_scan_epoch  = rd_rec.scan_epoch;
                    out_next.item_kind        = rd_rec.kind;
                    out_next.item_chunk_id    = rd_rec.chunk_id;
                    out_next.item_part_type   = rd_rec.part_type;
                    out_next.item_observed_ms = rd_rec.observed_ms;
                    out_next.pending_count    = CNT_W'(cnt_reg);
                    out_next.last             = (left_reg == LIMIT_W'(1));
                    if (left_reg == LIMIT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next record while this one is handed over
                        st_ctl.rd_en = 1'b1;
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        rd_seq_next  = rd_seq_reg + 64'd1;
                        left_next    = left_reg - LIMIT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            head_seq_reg  <= 64'd1;
            next_seq_reg  <= 64'd1;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            head_seq_reg  <= head_seq_next;
            next_seq_reg  <= next_seq_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and burst pointers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        rd_seq_reg <= rd_seq_next;
        out_reg    <= out_next;
    end

    sobx_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .wr_addr (tail_reg),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
